### rtl/fpma_pkg.sv
// Shared types and constants for the front panel menu auto-repeat unit.
`timescale 1ns / 1ps

package fpma_pkg;

  // Event kinds carried on the input tuser
  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;

  // Button codes
  localparam logic [1:0] BTN_PREV   = 2'd0;
  localparam logic [1:0] BTN_SELECT = 2'd1;
  localparam logic [1:0] BTN_NEXT   = 2'd2;
  localparam logic [1:0] BTN_NONE   = 2'd3;

  // Menu entries
  localparam logic [1:0] MENU_TONIC = 2'd0;
  localparam logic [1:0] MENU_MODE  = 2'd1;
  localparam logic [1:0] MENU_TEMPO = 2'd2;
  localparam logic [1:0] MENU_METRE = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_SLOW_REPEAT = 3'd0;
  localparam logic [2:0] CFG_FAST_REPEAT = 3'd1;
  localparam logic [2:0] CFG_LONG_PRESS  = 3'd2;
  localparam logic [2:0] CFG_REPEATS     = 3'd3;
  localparam logic [2:0] CFG_TEMPO_MIN   = 3'd4;
  localparam logic [2:0] CFG_TEMPO_MAX   = 3'd5;

  // Reset values
  localparam logic [15:0] SLOW_REPEAT_RST = 16'h16e2;
  localparam logic [15:0] FAST_REPEAT_RST = 16'h0492;
  localparam logic [15:0] LONG_PRESS_RST  = 16'h44a8;
  localparam logic [7:0]  REPEATS_RST     = 8'd3;
  localparam logic [7:0]  TEMPO_MIN_RST   = 8'd30;
  localparam logic [7:0]  TEMPO_MAX_RST   = 8'd240;
  localparam logic [7:0]  TEMPO_RST       = 8'd120;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] button;
    logic       playback_busy;
  } item_t;

  typedef struct packed {
    logic [15:0] slow_repeat_ticks;
    logic [15:0] fast_repeat_ticks;
    logic [15:0] long_press_ticks;
    logic [7:0]  repeats_before_fast;
    logic [7:0]  tempo_min;
    logic [7:0]  tempo_max;
  } cfg_t;

  typedef struct packed {
    logic [1:0] menu_item;
    logic [3:0] key_value;
    logic [1:0] mode_value;
    logic [7:0] tempo_value;
    logic [1:0] metre_value;
    logic       invert_flag;
  } settings_t;

endpackage

### rtl/front_panel_menu_autorepeat_unit.sv
// Top level of the front panel menu auto-repeat unit: beat registers and config.
//
//  channel | direction | tdata                                   | tuser
//  in_     | slave     | button[1:0], playback_busy[2]           | action[1:0]
//  out_    | master    | menu, key, mode, tempo, metre, inv, chg | -
//  cfg_    | write     | cfg_data[15:0] at cfg_index             | -
//
// One beat per cycle unless the output stalls; each beat sits in the input
// register, applied to the settings as it moves to the output register.
// Reset (synchronous, rst_n low) restores settings and config defaults.
// A stalled output holds its beat; the input register keeps taking beats
// while the output register is free or being drained in the same cycle.
`timescale 1ns / 1ps

module front_panel_menu_autorepeat_unit #(
  parameter int KEY_COUNT   = 12,
  parameter int MODE_COUNT  = 4,
  parameter int METRE_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // button[1:0], playback_busy[2], zero[7:3]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // menu_item[1:0], key_value[5:2], mode_value[7:6], tempo_value[15:8],
  // metre_value[17:16], invert_flag[18], changed[19], zero[23:20]
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import fpma_pkg::*;

  cfg_t      cfg_r;
  logic      in_valid_r;
  item_t     in_item_r;
  logic      out_valid_r;
  logic [23:0] out_data_r;
  logic      advance;
  settings_t set_nxt;
  logic      changed;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_repeat_ticks   <= SLOW_REPEAT_RST;
      cfg_r.fast_repeat_ticks   <= FAST_REPEAT_RST;
      cfg_r.long_press_ticks    <= LONG_PRESS_RST;
      cfg_r.repeats_before_fast <= REPEATS_RST;
      cfg_r.tempo_min           <= TEMPO_MIN_RST;
      cfg_r.tempo_max           <= TEMPO_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOW_REPEAT: cfg_r.slow_repeat_ticks   <= cfg_data;
        CFG_FAST_REPEAT: cfg_r.fast_repeat_ticks   <= cfg_data;
        CFG_LONG_PRESS:  cfg_r.long_press_ticks    <= cfg_data;
        CFG_REPEATS:     cfg_r.repeats_before_fast <= cfg_data[7:0];
        CFG_TEMPO_MIN:   cfg_r.tempo_min           <= cfg_data[7:0];
        CFG_TEMPO_MAX:   cfg_r.tempo_max           <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.action        <= in_tuser;
      in_item_r.button        <= in_tdata[1:0];
      in_item_r.playback_busy <= in_tdata[2];
    end
  end

  fpma_ctrl #(
    .KEY_COUNT   (KEY_COUNT),
    .MODE_COUNT  (MODE_COUNT),
    .METRE_COUNT (METRE_COUNT)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .set_nxt (set_nxt),
    .changed (changed)
  );

  // Output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {4'd0, changed, set_nxt.invert_flag, set_nxt.metre_value,
                     set_nxt.tempo_value, set_nxt.mode_value, set_nxt.key_value,
                     set_nxt.menu_item};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/fpma_ctrl.sv
// Settings state, hold timer and per-event update logic.
`timescale 1ns / 1ps

module fpma_ctrl #(
  parameter int KEY_COUNT   = 12,
  parameter int MODE_COUNT  = 4,
  parameter int METRE_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  fpma_pkg::item_t     item,
  input  fpma_pkg::cfg_t      cfg,
  output fpma_pkg::settings_t set_nxt,
  output logic                changed
);
  import fpma_pkg::*;

  localparam logic [3:0] KEY_LAST   = 4'(KEY_COUNT - 1);
  localparam logic [1:0] MODE_LAST  = 2'(MODE_COUNT - 1);
  localparam logic [1:0] METRE_LAST = 2'(METRE_COUNT - 1);

  settings_t   set_r;
  logic        held_r, held_nxt;
  logic [1:0]  held_btn_r, held_btn_nxt;
  logic        timer_on_r, timer_on_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        use_fast_r, use_fast_nxt;
  logic [7:0]  fire_r, fire_nxt;
  logic        settled_r, settled_nxt;

  // Step the selected setting up or down
  function automatic settings_t adjust(input settings_t s, input logic up,
                                       input logic [7:0] tmin, input logic [7:0] tmax);
    settings_t r;
    r = s;
    unique case (s.menu_item)
      MENU_TONIC: begin
        if (up) r.key_value = (s.key_value >= KEY_LAST) ? 4'd0 : s.key_value + 4'd1;
        else    r.key_value = (s.key_value == 4'd0 || s.key_value > KEY_LAST) ?
                              KEY_LAST : s.key_value - 4'd1;
      end
      MENU_MODE: begin
        if (up) r.mode_value = (s.mode_value >= MODE_LAST) ? 2'd0 : s.mode_value + 2'd1;
        else    r.mode_value = (s.mode_value == 2'd0 || s.mode_value > MODE_LAST) ?
                               MODE_LAST : s.mode_value - 2'd1;
      end
      MENU_TEMPO: begin
        if (up) begin
          if (s.tempo_value < tmax) r.tempo_value = s.tempo_value + 8'd1;
        end else begin
          if (s.tempo_value > tmin) r.tempo_value = s.tempo_value - 8'd1;
        end
      end
      MENU_METRE: begin
        if (up) r.metre_value = (s.metre_value >= METRE_LAST) ? 2'd0 : s.metre_value + 2'd1;
        else    r.metre_value = (s.metre_value == 2'd0 || s.metre_value > METRE_LAST) ?
                                METRE_LAST : s.metre_value - 2'd1;
      end
      default: r = s;
    endcase
    return r;
  endfunction

  logic        sel_held;
  logic [15:0] period;
  logic [16:0] tick_inc;

  assign sel_held = (held_btn_r == BTN_SELECT);
  assign period   = sel_held ? cfg.long_press_ticks :
                    (use_fast_r ? cfg.fast_repeat_ticks : cfg.slow_repeat_ticks);
  assign tick_inc = {1'b0, tick_r} + 17'd1;

  // Next state for one event
  always_comb begin
    set_nxt      = set_r;
    held_nxt     = held_r;
    held_btn_nxt = held_btn_r;
    timer_on_nxt = timer_on_r;
    tick_nxt     = tick_r;
    use_fast_nxt = use_fast_r;
    fire_nxt     = fire_r;
    settled_nxt  = settled_r;
    unique case (item.action)
      ACT_PRESS: begin
        if (!held_r && item.button != BTN_NONE) begin
          held_btn_nxt = item.button;
          if (item.button == BTN_SELECT) set_nxt.menu_item = set_r.menu_item + 2'd1;
          else set_nxt = adjust(set_r, item.button == BTN_NEXT, cfg.tempo_min, cfg.tempo_max);
          if (!item.playback_busy) begin
            timer_on_nxt = 1'b1;
            tick_nxt     = '0;
            use_fast_nxt = 1'b0;
            fire_nxt     = '0;
            settled_nxt  = 1'b0;
          end
          held_nxt = 1'b1;
        end
      end
      ACT_RELEASE: begin
        held_nxt = 1'b0;
        if (!item.playback_busy) timer_on_nxt = 1'b0;
      end
      ACT_TICK: begin
        if (timer_on_r) begin
          if (tick_inc >= {1'b0, period}) begin
            // Fire: reload and run the repeat action
            tick_nxt = '0;
            if (sel_held) set_nxt.invert_flag = ~set_r.invert_flag;
            else set_nxt = adjust(set_r, held_btn_r == BTN_NEXT, cfg.tempo_min, cfg.tempo_max);
            if (!settled_r) begin
              if (sel_held || cfg.repeats_before_fast == 8'd0) begin
                timer_on_nxt = 1'b0;
                settled_nxt  = 1'b1;
              end else begin
                fire_nxt = fire_r + 8'd1;
                if (fire_nxt == cfg.repeats_before_fast) begin
                  use_fast_nxt = 1'b1;
                  settled_nxt  = 1'b1;
                end
              end
            end
          end else begin
            tick_nxt = tick_inc[15:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign changed = (set_nxt != set_r);

  // Hold state, update on each event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r       <= '{menu_item: MENU_TONIC, key_value: 4'd0, mode_value: 2'd0,
                       tempo_value: TEMPO_RST, metre_value: 2'd0, invert_flag: 1'b0};
      held_r      <= 1'b0;
      held_btn_r  <= BTN_PREV;
      timer_on_r  <= 1'b0;
      tick_r      <= '0;
      use_fast_r  <= 1'b0;
      fire_r      <= '0;
      settled_r   <= 1'b0;
    end else if (step_en) begin
      set_r       <= set_nxt;
      held_r      <= held_nxt;
      held_btn_r  <= held_btn_nxt;
      timer_on_r  <= timer_on_nxt;
      tick_r      <= tick_nxt;
      use_fast_r  <= use_fast_nxt;
      fire_r      <= fire_nxt;
      settled_r   <= settled_nxt;
    end
  end

endmodule

### tb/front_panel_menu_autorepeat_unit_tb.sv
// Self-checking testbench for the front panel menu auto-repeat unit.
`timescale 1ns / 1ps

module front_panel_menu_autorepeat_unit_tb;
  import fpma_pkg::*;

  localparam int KEY_COUNT   = 12;
  localparam int MODE_COUNT  = 4;
  localparam int METRE_COUNT = 4;

  // Event code the block must ignore
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  localparam int PHASE_COUNT = 6;
  localparam int PHASE_BEATS = 330;
  localparam int SETTLE_CYCLES = 4;
  localparam int PLAN_LEN = 32;
  localparam int MAX_REPORTS = 10;

  // Same field order as settings_t, with the change flag last
  typedef struct packed {
    logic [1:0] menu;
    logic [3:0] key;
    logic [1:0] mode;
    logic [7:0] tempo;
    logic [1:0] metre;
    logic       invert;
    logic       changed;
  } panel_result_t;

  typedef struct {
    bit            is_write;   // register write instead of a beat
    logic [2:0]    idx;
    logic [15:0]   val;
    logic [1:0]    act;
    logic [1:0]    btn;
    logic          busy;
    bit            typed;      // want holds the expected result
    panel_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // button[1:0], playback_busy[2], zero[7:3]
  logic [1:0]  in_tuser = '0;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // menu_item[1:0], key_value[5:2], mode_value[7:6], tempo_value[15:8],
  // metre_value[17:16], invert_flag[18], changed[19], zero[23:20]
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  front_panel_menu_autorepeat_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the panel state and its register file
  cfg_t        panel_cfg = '{SLOW_REPEAT_RST, FAST_REPEAT_RST, LONG_PRESS_RST,
                             REPEATS_RST, TEMPO_MIN_RST, TEMPO_MAX_RST};
  settings_t   panel = '{MENU_TONIC, 4'd0, 2'd0, TEMPO_RST, 2'd0, 1'b0};
  logic        held = 1'b0;
  logic [1:0]  held_btn = BTN_PREV;
  logic        timer_on = 1'b0;
  logic [15:0] tick_count = '0;
  logic        use_fast = 1'b0;
  logic [7:0]  fire_count = '0;
  logic        settled = 1'b0;

  panel_result_t expected_panels[$];
  int tx_idle_pct = 16;
  int rx_idle_pct = 84;
  int beats_sent = 0;
  int results_seen = 0;
  int errors = 0;
  int repeat_fires = 0;
  int invert_toggles = 0;

  // Directed walk; expected values typed in only for the opening rows
  // want: menu, key, mode, tempo, metre, invert, changed
  plan_row_t plan [PLAN_LEN] = '{
    // wrap key down from zero, then a second press while held is dropped
    '{0, 3'd0, 16'd0, ACT_PRESS, BTN_PREV, 1'b0, 1, '{MENU_TONIC, 4'd11, 2'd0, 8'd120, 2'd0, 1'b0, 1'b1}},
    '{0, 3'd0, 16'd0, ACT_PRESS, BTN_NEXT, 1'b0, 1, '{MENU_TONIC, 4'd11, 2'd0, 8'd120, 2'd0, 1'b0, 1'b0}},
    '{0, 3'd0, 16'd0, ACT_RELEASE, BTN_PREV, 1'b0, 1, '{MENU_TONIC, 4'd11, 2'd0, 8'd120, 2'd0, 1'b0, 1'b0}},
    '{0, 3'd0, 16'd0, ACT_PRESS, BTN_NEXT, 1'b0, 1, '{MENU_TONIC, 4'd0, 2'd0, 8'd120, 2'd0, 1'b0, 1'b1}},
    // release during playback leaves the timer running
    '{0, 3'd0, 16'd0, ACT_RELEASE, BTN_PREV, 1'b1, 1, '{MENU_TONIC, 4'd0, 2'd0, 8'd120, 2'd0, 1'b0, 1'b0}},
    '{0, 3'd0, 16'd0, ACT_TICK, BTN_SELECT, 1'b0, 1, '{MENU_TONIC, 4'd0, 2'd0, 8'd120, 2'd0, 1'b0, 1'b0}},
    // unknown action and unknown button do nothing
    '{0, 3'd0, 16'd0, ACT_UNKNOWN, BTN_NONE, 1'b1, 1, '{MENU_TONIC, 4'd0, 2'd0, 8'd120, 2'd0, 1'b0, 1'b0}},
    '{0, 3'd0, 16'd0, ACT_PRESS, BTN_NONE, 1'b0, 1, '{MENU_TONIC, 4'd0, 2'd0, 8'd120, 2'd0, 1'b0, 1'b0}},
    '{0, 3'd0, 16'd0, ACT_PRESS, BTN_SELECT, 1'b1, 1, '{MENU_MODE, 4'd0, 2'd0, 8'd120, 2'd0, 1'b0, 1'b1}},
    '{0, 3'd0, 16'd0, ACT_RELEASE, BTN_NEXT, 1'b0, 1, '{MENU_MODE, 4'd0, 2'd0, 8'd120, 2'd0, 1'b0, 1'b0}},
    '{0, 3'd0, 16'd0, ACT_PRESS, BTN_SELECT, 1'b0, 1, '{MENU_TEMPO, 4'd0, 2'd0, 8'd120, 2'd0, 1'b0, 1'b1}},
    '{0, 3'd0, 16'd0, ACT_RELEASE, BTN_PREV, 1'b0, 1, '{MENU_TEMPO, 4'd0, 2'd0, 8'd120, 2'd0, 1'b0, 1'b0}},
    // zero slow period fires on every tick; tempo held at its upper limit
    '{1, CFG_SLOW_REPEAT, 16'd0, ACT_PRESS, BTN_PREV, 1'b0, 0, '0},
    '{1, CFG_REPEATS, 16'd2, ACT_PRESS, BTN_PREV, 1'b0, 0, '0},
    '{1, CFG_TEMPO_MAX, 16'd121, ACT_PRESS, BTN_PREV, 1'b0, 0, '0},
    '{0, 3'd0, 16'd0, ACT_PRESS, BTN_NEXT, 1'b0, 0, '0},
    '{0, 3'd0, 16'd0, ACT_TICK, BTN_PREV, 1'b0, 0, '0},
    '{0, 3'd0, 16'd0, ACT_TICK, BTN_NEXT, 1'b1, 0, '0},
    '{0, 3'd0, 16'd0, ACT_RELEASE, BTN_NEXT, 1'b0, 0, '0},
    // crossed tempo limits block a step down
    '{1, CFG_TEMPO_MIN, 16'd200, ACT_PRESS, BTN_PREV, 1'b0, 0, '0},
    '{0, 3'd0, 16'd0, ACT_PRESS, BTN_PREV, 1'b0, 0, '0},
    '{0, 3'd0, 16'd0, ACT_RELEASE, BTN_PREV, 1'b0, 0, '0},
    // long select press toggles invert once, then the timer stops
    '{1, CFG_LONG_PRESS, 16'd1, ACT_PRESS, BTN_PREV, 1'b0, 0, '0},
    '{0, 3'd0, 16'd0, ACT_PRESS, BTN_SELECT, 1'b0, 0, '0},
    '{0, 3'd0, 16'd0, ACT_TICK, BTN_PREV, 1'b0, 0, '0},
    '{0, 3'd0, 16'd0, ACT_TICK, BTN_PREV, 1'b0, 0, '0},
    '{0, 3'd0, 16'd0, ACT_RELEASE, BTN_PREV, 1'b0, 0, '0},
    // one-shot repeat on metre
    '{1, CFG_REPEATS, 16'd0, ACT_PRESS, BTN_PREV, 1'b0, 0, '0},
    '{1, CFG_SLOW_REPEAT, 16'd1, ACT_PRESS, BTN_PREV, 1'b0, 0, '0},
    '{0, 3'd0, 16'd0, ACT_PRESS, BTN_PREV, 1'b0, 0, '0},
    '{0, 3'd0, 16'd0, ACT_TICK, BTN_PREV, 1'b0, 0, '0},
    '{0, 3'd0, 16'd0, ACT_RELEASE, BTN_PREV, 1'b0, 0, '0}
  };

  function automatic int wrap_inc(int v, int n);
    return (v + 1 >= n) ? 0 : v + 1;
  endfunction

  function automatic int wrap_dec(int v, int n);
    return (v == 0 || v >= n) ? n - 1 : v - 1;
  endfunction

  // Step the selected setting up or down
  task automatic adjust_setting(input bit up);
    case (panel.menu_item)
      MENU_TONIC: begin
        panel.key_value = 4'(up ? wrap_inc(int'(panel.key_value), KEY_COUNT)
                                : wrap_dec(int'(panel.key_value), KEY_COUNT));
      end
      MENU_MODE: begin
        panel.mode_value = 2'(up ? wrap_inc(int'(panel.mode_value), MODE_COUNT)
                                 : wrap_dec(int'(panel.mode_value), MODE_COUNT));
      end
      MENU_TEMPO: begin
        if (up) begin
          if (panel.tempo_value < panel_cfg.tempo_max) panel.tempo_value++;
        end else begin
          if (panel.tempo_value > panel_cfg.tempo_min) panel.tempo_value--;
        end
      end
      default: begin
        panel.metre_value = 2'(up ? wrap_inc(int'(panel.metre_value), METRE_COUNT)
                                  : wrap_dec(int'(panel.metre_value), METRE_COUNT));
      end
    endcase
  endtask

  // Apply one event to the shadow panel and return the settings it leaves
  task automatic apply_panel_event(input logic [1:0] act, input logic [1:0] btn,
                                   input logic busy, output panel_result_t res);
    settings_t   prior;
    logic [15:0] period;
    logic [16:0] nxt;
    bit          sel;
    prior = panel;
    case (act)
      ACT_PRESS: begin
        if (!held && btn != BTN_NONE) begin
          held_btn = btn;
          if (btn == BTN_SELECT) panel.menu_item = panel.menu_item + 2'd1;
          else adjust_setting(btn == BTN_NEXT);
          if (!busy) begin
            timer_on = 1'b1;
            tick_count = '0;
            use_fast = 1'b0;
            fire_count = '0;
            settled = 1'b0;
          end
          held = 1'b1;
        end
      end
      ACT_RELEASE: begin
        held = 1'b0;
        if (!busy) timer_on = 1'b0;
      end
      ACT_TICK: begin
        if (timer_on) begin
          sel = (held_btn == BTN_SELECT);
          period = sel ? panel_cfg.long_press_ticks
                       : (use_fast ? panel_cfg.fast_repeat_ticks
                                   : panel_cfg.slow_repeat_ticks);
          nxt = {1'b0, tick_count} + 17'd1;
          if (nxt >= {1'b0, period}) begin
            // fire and reload
            tick_count = '0;
            repeat_fires++;
            if (sel) begin
              panel.invert_flag = ~panel.invert_flag;
              invert_toggles++;
            end else begin
              adjust_setting(held_btn == BTN_NEXT);
            end
            if (!settled) begin
              if (sel || panel_cfg.repeats_before_fast == 8'd0) begin
                timer_on = 1'b0;
                settled = 1'b1;
              end else begin
                fire_count = fire_count + 8'd1;
                if (fire_count == panel_cfg.repeats_before_fast) begin
                  use_fast = 1'b1;
                  settled = 1'b1;
                end
              end
            end
          end else begin
            tick_count = nxt[15:0];
          end
        end
      end
      default: ;
    endcase
    res = {panel, panel != prior};
  endtask

  // Offer one beat, idling at random first; predict it once accepted
  task automatic send_beat(input logic [1:0] act, input logic [1:0] btn, input logic busy,
                           input bit typed = 1'b0, input panel_result_t want = '0);
    panel_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {5'd0, busy, btn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_panel_event(act, btn, busy, res);
    expected_panels.push_back(typed ? want : res);
    beats_sent++;
  endtask

  // Hold the input until every expected result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_panels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; the caller lowers cfg_we after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SLOW_REPEAT: panel_cfg.slow_repeat_ticks = val;
      CFG_FAST_REPEAT: panel_cfg.fast_repeat_ticks = val;
      CFG_LONG_PRESS:  panel_cfg.long_press_ticks = val;
      CFG_REPEATS:     panel_cfg.repeats_before_fast = val[7:0];
      CFG_TEMPO_MIN:   panel_cfg.tempo_min = val[7:0];
      CFG_TEMPO_MAX:   panel_cfg.tempo_max = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Mostly press, a run of ticks and a release; the rest is loose noise
  task automatic run_traffic(input int count);
    int first;
    int ticks;
    logic busy;
    first = beats_sent;
    while (beats_sent - first < count) begin
      if ($urandom_range(99) < 80) begin
        busy = ($urandom_range(3) == 0);
        send_beat(ACT_PRESS, 2'($urandom_range(2)), busy);
        ticks = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(12);
        repeat (ticks) send_beat(ACT_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
        send_beat(ACT_RELEASE, 2'($urandom_range(3)), $urandom_range(3) == 0);
      end else begin
        send_beat(2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Result side: random stall, check each beat against the oldest expectation
  always @(posedge clk) begin
    panel_result_t got;
    panel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[1:0], out_tdata[5:2], out_tdata[7:6], out_tdata[15:8],
              out_tdata[17:16], out_tdata[18], out_tdata[19]};
      results_seen++;
      if (expected_panels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result %0d arrived with nothing expected: %h", results_seen, got);
      end else begin
        want = expected_panels.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("result %0d mismatch:", results_seen);
            $display("  exp menu=%0d key=%0d mode=%0d tempo=%0d metre=%0d inv=%0d chg=%0d",
                     want.menu, want.key, want.mode, want.tempo, want.metre,
                     want.invert, want.changed);
            $display("  got menu=%0d key=%0d mode=%0d tempo=%0d metre=%0d inv=%0d chg=%0d",
                     got.menu, got.key, got.mode, got.tempo, got.metre,
                     got.invert, got.changed);
          end
        end
      end
    end
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    logic [15:0] slow_p;
    logic [15:0] fast_p;
    logic [15:0] long_p;
    logic [7:0]  reps;
    logic [7:0]  t_min;
    logic [7:0]  t_max;
    int          directed_beats;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!cfg_we) drain_results();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        send_beat(plan[i].act, plan[i].btn, plan[i].busy, plan[i].typed, plan[i].want);
      end
    end
    directed_beats = beats_sent;

    // Random phases, each under its own register settings
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      tx_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 84 : 0;
      rx_idle_pct = (ph < 2) ? 84 : (ph < 4) ? 16 : 0;
      drain_results();
      case (ph)
        1: begin
          // fastest repeat, widest tempo range, longest select hold
          slow_p = 16'd1; fast_p = 16'd1; long_p = 16'hFFFF;
          reps = 8'd255; t_min = 8'd1; t_max = 8'd255;
        end
        2: begin
          // slowest repeat, one shot, limits crossed at the extremes
          slow_p = 16'hFFFF; fast_p = 16'hFFFF; long_p = 16'd1;
          reps = 8'd0; t_min = 8'd255; t_max = 8'd1;
        end
        default: begin
          slow_p = 16'($urandom_range(1, 6));
          fast_p = 16'($urandom_range(1, 3));
          long_p = 16'($urandom_range(1, 8));
          reps = 8'($urandom_range(0, 4));
          if (ph == 4) begin
            t_min = 8'($urandom_range(1, 255));
            t_max = 8'($urandom_range(1, 255));
          end else begin
            t_min = 8'($urandom_range(110, 122));
            t_max = 8'($urandom_range(118, 130));
          end
        end
      endcase
      write_reg(CFG_SLOW_REPEAT, slow_p);
      write_reg(CFG_FAST_REPEAT, fast_p);
      write_reg(CFG_LONG_PRESS, long_p);
      write_reg(CFG_REPEATS, {8'd0, reps});
      write_reg(CFG_TEMPO_MIN, {8'd0, t_min});
      write_reg(CFG_TEMPO_MAX, {8'd0, t_max});
      cfg_we <= 1'b0;
      run_traffic(PHASE_BEATS);
    end

    drain_results();
    $display("covered %0d beats (%0d directed) over %0d register settings, %0d results",
             beats_sent, directed_beats, PHASE_COUNT, results_seen);
    $display("auto-repeat fired %0d times, invert toggled %0d times, %0d errors",
             repeat_fires, invert_toggles, errors);
    if (errors == 0 && expected_panels.size() == 0) begin
      $display("** front_panel_menu_autorepeat_unit: PASSED **");
    end else begin
      $display("** front_panel_menu_autorepeat_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results still expected", expected_panels.size());
    $display("** front_panel_menu_autorepeat_unit: FAILED **");
    $finish;
  end

endmodule
